@@ hw/rtl/mlfq_pkg.sv @@
// Package for the multilevel feedback scheduler: sizes, codes and the
// request/result types shared by the sequencer and the top level.
// No dependencies.
package mlfq_pkg;

    localparam int MaxTasks = 128;
    localparam int IdxW     = $clog2(MaxTasks);
    localparam int CntW     = $clog2(MaxTasks + 1);
    localparam int LvlDepth = 3 * MaxTasks;
    localparam int LvlAw    = $clog2(LvlDepth);

    localparam logic [1:0] MODE_ADMIT    = 2'd0;
    localparam logic [1:0] MODE_DISPATCH = 2'd1;
    localparam logic [1:0] MODE_OUTCOME  = 2'd2;

    localparam logic [1:0] OC_EXPIRED = 2'd0;
    localparam logic [1:0] OC_IO      = 2'd1;
    localparam logic [1:0] OC_FINISH  = 2'd2;
    localparam logic [1:0] OC_NONE    = 2'd3;

    localparam logic [2:0] KIND_ADMITTED   = 3'd0;
    localparam logic [2:0] KIND_DISPATCHED = 3'd1;
    localparam logic [2:0] KIND_IDLE_IO    = 3'd2;
    localparam logic [2:0] KIND_IDLE_EMPTY = 3'd3;
    localparam logic [2:0] KIND_APPLIED    = 3'd4;
    localparam logic [2:0] KIND_ERROR      = 3'd5;

    localparam int CfgBaseQuantum = 0;
    localparam int CfgIoDelay     = 1;

    // One scheduler request.
    typedef struct packed {
        logic [31:0] now_seconds;
        logic [1:0]  outcome;
        logic [6:0]  task_id;
        logic [1:0]  mode;
    } req_t;

    // One scheduler result.
    typedef struct packed {
        logic [7:0] released_count;
        logic [9:0] quantum;
        logic [1:0] run_level;
        logic [6:0] run_id;
        logic [2:0] kind;
    } res_t;

endpackage

@@ hw/rtl/mlfq_ram.sv @@
// Generic single-port write, single-port read RAM with registered read.
// No dependencies.
module mlfq_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);

    logic [Width-1:0] mem [Depth];

    // Write and registered read.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hw/rtl/mlfq_seq.sv @@
// Sequencer of the scheduler: queue pointers, running task and the step
// engine that walks the I/O release loop one head at a time.
// Depends on mlfq_pkg and mlfq_ram.
module mlfq_seq import mlfq_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       start,
    input  req_t       req,
    input  logic [7:0] base_quantum,
    input  logic [7:0] io_delay,
    output logic       busy,
    output logic       done,
    output res_t       res
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DISP  = 3'd1;
    localparam logic [2:0] ST_RREQ  = 3'd2;
    localparam logic [2:0] ST_RCHK  = 3'd3;
    localparam logic [2:0] ST_APPLY = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0]      state_reg, state_next;
    req_t            req_reg, req_next;
    res_t            res_reg, res_next;
    logic [IdxW-1:0] head_reg [3];
    logic [IdxW-1:0] head_next [3];
    logic [CntW-1:0] cnt_reg [3];
    logic [CntW-1:0] cnt_next [3];
    logic [IdxW-1:0] io_head_reg, io_head_next;
    logic [CntW-1:0] io_cnt_reg, io_cnt_next;
    logic [6:0]      run_task_reg, run_task_next;
    logic [1:0]      run_lvl_reg, run_lvl_next;
    logic            run_valid_reg, run_valid_next;
    logic [1:0]      disp_lvl_reg, disp_lvl_next;

    // Memory ports.
    logic             lv_we;
    logic [LvlAw-1:0] lv_waddr, lv_raddr;
    logic [6:0]       lv_wdata, lv_rdata;
    logic             io_we;
    logic [IdxW-1:0]  io_waddr, io_raddr;
    logic [40:0]      io_wdata, io_rdata;

    mlfq_ram #(.Width(7), .Depth(LvlDepth)) u_lvl_ram (
        .aclk(aclk), .we(lv_we), .waddr(lv_waddr), .wdata(lv_wdata),
        .raddr(lv_raddr), .rdata(lv_rdata)
    );

    // I/O entry: {return level, stamp, id}.
    mlfq_ram #(.Width(41), .Depth(MaxTasks)) u_io_ram (
        .aclk(aclk), .we(io_we), .waddr(io_waddr), .wdata(io_wdata),
        .raddr(io_raddr), .rdata(io_rdata)
    );

    function automatic logic [LvlAw-1:0] lv_addr(input logic [1:0] lv,
                                                 input logic [IdxW-1:0] idx);
        lv_addr = LvlAw'(lv) * LvlAw'(MaxTasks) + LvlAw'(idx);
    endfunction

    function automatic logic [IdxW-1:0] tail(input logic [IdxW-1:0] h,
                                             input logic [CntW-1:0] c);
        logic [CntW:0] s;
        s = (CntW+1)'(h) + (CntW+1)'(c);
        tail = s[IdxW-1:0];
    endfunction

    // Shared release-check arithmetic on the I/O head.
    logic [1:0]  io_lv;
    logic [31:0] io_st;
    logic [32:0] io_diff;
    logic        io_due;
    always_comb begin
        io_lv   = (io_rdata[40:39] > 2'd2) ? 2'd2 : io_rdata[40:39];
        io_st   = io_rdata[38:7];
        io_diff = {1'b0, req_reg.now_seconds} - {1'b0, io_st};
        io_due  = !io_diff[32] && (io_diff[31:0] >= {24'd0, io_delay});
    end

    // Step logic.
    always_comb begin
        logic [1:0] lv;
        logic       found;
        state_next     = state_reg;
        req_next       = req_reg;
        res_next       = res_reg;
        head_next      = head_reg;
        cnt_next       = cnt_reg;
        io_head_next   = io_head_reg;
        io_cnt_next    = io_cnt_reg;
        run_task_next  = run_task_reg;
        run_lvl_next   = run_lvl_reg;
        run_valid_next = run_valid_reg;
        disp_lvl_next  = disp_lvl_reg;
        lv_we    = 1'b0;
        lv_waddr = '0;
        lv_wdata = '0;
        lv_raddr = '0;
        io_we    = 1'b0;
        io_waddr = '0;
        io_wdata = '0;
        io_raddr = io_head_reg;
        lv = 2'd0;
        found = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    req_next = req;
                    res_next = '0;
                    res_next.kind = KIND_ERROR;
                    state_next = ST_DONE;
                    case (req.mode)
                        MODE_ADMIT: begin
                            if (cnt_reg[0] < CntW'(MaxTasks)) begin
                                lv_we    = 1'b1;
                                lv_waddr = lv_addr(2'd0, tail(head_reg[0], cnt_reg[0]));
                                lv_wdata = req.task_id;
                                cnt_next[0] = cnt_reg[0] + 1'b1;
                                res_next.kind = KIND_ADMITTED;
                            end
                        end
                        MODE_DISPATCH: begin
                            if (!run_valid_reg) begin
                                for (int i = 2; i >= 0; i--) begin
                                    if (cnt_reg[i] != '0) begin
                                        lv = 2'(i);
                                        found = 1'b1;
                                    end
                                end
                                if (found) begin
                                    lv_raddr      = lv_addr(lv, head_reg[lv]);
                                    disp_lvl_next = lv;
                                    head_next[lv] = head_reg[lv] + 1'b1;
                                    cnt_next[lv]  = cnt_reg[lv] - 1'b1;
                                    state_next    = ST_DISP;
                                end else if (io_cnt_reg != '0) begin
                                    res_next.kind = KIND_IDLE_IO;
                                end else begin
                                    res_next.kind = KIND_IDLE_EMPTY;
                                end
                            end
                        end
                        MODE_OUTCOME: state_next = ST_RREQ;
                        default: ;
                    endcase
                end
            end
            ST_DISP: begin
                res_next.kind      = KIND_DISPATCHED;
                res_next.run_id    = lv_rdata;
                res_next.run_level = disp_lvl_reg;
                res_next.quantum   = 10'({2'b00, base_quantum} << disp_lvl_reg);
                run_task_next  = lv_rdata;
                run_lvl_next   = disp_lvl_reg;
                run_valid_next = 1'b1;
                state_next     = ST_DONE;
            end
            ST_RREQ: begin
                // Read data for the current I/O head arrives next cycle.
                state_next = (io_cnt_reg != '0) ? ST_RCHK : ST_APPLY;
            end
            ST_RCHK: begin
                if (io_due && cnt_reg[io_lv] < CntW'(MaxTasks)) begin
                    lv_we    = 1'b1;
                    lv_waddr = lv_addr(io_lv, tail(head_reg[io_lv], cnt_reg[io_lv]));
                    lv_wdata = io_rdata[6:0];
                    cnt_next[io_lv] = cnt_reg[io_lv] + 1'b1;
                    io_head_next = io_head_reg + 1'b1;
                    io_cnt_next  = io_cnt_reg - 1'b1;
                    res_next.released_count = res_reg.released_count + 1'b1;
                    state_next = ST_RREQ;
                end else begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY: begin
                res_next.kind = KIND_APPLIED;
                state_next = ST_DONE;
                if (req_reg.outcome != OC_NONE) begin
                    if (!run_valid_reg) begin
                        res_next.kind = KIND_ERROR;
                    end else begin
                        run_valid_next = 1'b0;
                        if (req_reg.outcome == OC_EXPIRED) begin
                            lv = (run_lvl_reg >= 2'd2) ? 2'd2 : run_lvl_reg + 2'd1;
                            if (cnt_reg[lv] < CntW'(MaxTasks)) begin
                                lv_we    = 1'b1;
                                lv_waddr = lv_addr(lv, tail(head_reg[lv], cnt_reg[lv]));
                                lv_wdata = run_task_reg;
                                cnt_next[lv] = cnt_reg[lv] + 1'b1;
                            end else begin
                                res_next.kind = KIND_ERROR;
                            end
                        end else if (req_reg.outcome == OC_IO) begin
                            lv = (run_lvl_reg == 2'd0) ? 2'd0 : run_lvl_reg - 2'd1;
                            if (lv > 2'd2) lv = 2'd2;
                            if (io_cnt_reg < CntW'(MaxTasks)) begin
                                io_we    = 1'b1;
                                io_waddr = tail(io_head_reg, io_cnt_reg);
                                io_wdata = {lv, req_reg.now_seconds, run_task_reg};
                                io_cnt_next = io_cnt_reg + 1'b1;
                            end else begin
                                res_next.kind = KIND_ERROR;
                            end
                        end
                    end
                end
            end
            ST_DONE: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            head_reg      <= '{default: '0};
            cnt_reg       <= '{default: '0};
            io_head_reg   <= '0;
            io_cnt_reg    <= '0;
            run_task_reg  <= '0;
            run_lvl_reg   <= '0;
            run_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            cnt_reg       <= cnt_next;
            io_head_reg   <= io_head_next;
            io_cnt_reg    <= io_cnt_next;
            run_task_reg  <= run_task_next;
            run_lvl_reg   <= run_lvl_next;
            run_valid_reg <= run_valid_next;
        end
        req_reg      <= req_next;
        res_reg      <= res_next;
        disp_lvl_reg <= disp_lvl_next;
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = (state_reg == ST_DONE);
    assign res  = res_reg;

`ifndef SYNTH
    // Queue counts never exceed their capacity.
    a_cnt_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg[0] <= CntW'(MaxTasks) && cnt_reg[1] <= CntW'(MaxTasks) &&
        cnt_reg[2] <= CntW'(MaxTasks) && io_cnt_reg <= CntW'(MaxTasks))
        else $error("queue count over capacity");
    // A dispatch always leaves a task running.
    a_disp_runs: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DISP |=> run_valid_reg)
        else $error("dispatch left nothing running");
    // A release check only happens with a waiter present.
    a_rchk_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_RCHK |-> io_cnt_reg != '0)
        else $error("release check on empty I/O queue");
`endif

endmodule

@@ hw/rtl/multilevel_feedback_scheduler_unit.sv @@
// Multilevel feedback scheduler: one request at a time, one result each.
// Admit, idle-dispatch, busy-dispatch and bad-mode results follow accept directly;
// a queued-task dispatch reads the level RAM first. An outcome releases due I/O
// waiters until none is left, one is not yet due or its level is full.
// The next request is accepted the cycle after the result is taken.
// Reset (aresetn, synchronous, active low) empties all queues, clears the
// running task and loads base_quantum = 2 and io_delay = 3.
module multilevel_feedback_scheduler_unit import mlfq_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // mode[1:0], task_id[8:2], outcome[10:9], now_seconds[42:11], zeros
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // kind[2:0], run_id[9:3], run_level[11:10], quantum[21:12],
    // released_count[29:22], zeros
    output logic [31:0] m_tdata
);

    logic [7:0] base_quantum_reg, io_delay_reg;
    logic       busy, done, start;
    res_t       res;
    req_t       req;
    logic       out_valid_reg;
    res_t       out_reg;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_quantum_reg <= 8'd2;
            io_delay_reg     <= 8'd3;
        end else if (cfg_we) begin
            if (cfg_index == 1'(CfgBaseQuantum)) base_quantum_reg <= cfg_data;
            if (cfg_index == 1'(CfgIoDelay))     io_delay_reg     <= cfg_data;
        end
    end

    assign req      = req_t'(s_tdata[42:0]);
    assign s_tready = !busy && !out_valid_reg;
    assign start    = s_tvalid && s_tready;

    mlfq_seq u_seq (
        .aclk(aclk), .aresetn(aresetn), .start(start), .req(req),
        .base_quantum(base_quantum_reg), .io_delay(io_delay_reg),
        .busy(busy), .done(done), .res(res)
    );

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (done) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (done) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_reg};

`ifndef SYNTH
    // No new request while a result is pending.
    a_no_accept_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> !s_tready)
        else $error("accepted while result pending");
    // A finished step never overwrites an untaken result.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        done |-> !out_valid_reg)
        else $error("result overwritten");
    // Result kind is always a defined code.
    a_kind_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[2:0] <= KIND_ERROR)
        else $error("bad result kind");
`endif

endmodule
